@@ design/utf8v_pkg.sv @@
// Package for the strict UTF-8 validator with line and column tracking.
// Holds counter widths, byte class limits, scalar limits and the step result type.
// No dependencies.
package utf8v_pkg;

  localparam int unsigned LINE_BITS   = 24;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned SCALAR_BITS = 21;

  // Lead byte ranges that open multi-byte sequences.
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // Continuation bytes carry this tag in their two top bits.
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Sequence length codes.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // Scalar limits.
  localparam logic [SCALAR_BITS-1:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [SCALAR_BITS-1:0] MIN_FOUR_BYTE  = 21'h010000;
  localparam logic [SCALAR_BITS-1:0] SURROGATE_LO   = 21'h00D800;
  localparam logic [SCALAR_BITS-1:0] SURROGATE_HI   = 21'h00DFFF;
  localparam logic [SCALAR_BITS-1:0] SCALAR_MAX     = 21'h10FFFF;
  localparam logic [SCALAR_BITS-1:0] NEWLINE        = 21'h00000A;

  // What one byte produces, passed from the decoder to the position counters
  // and the result register.
  typedef struct packed {
    logic                   done;
    logic [SCALAR_BITS-1:0] value;
    logic                   error;
    logic                   last;
  } utf8v_step_t;

endpackage

@@ design/utf8v_validate_top.sv @@
// The result of an accepted byte is held in the output register from the next cycle on.
// Throughput: one byte per cycle while the consumer keeps out_ready_i high; the output
// register takes a new result in the same cycle that the held one is transferred out.
// Reset (rst_ni, asynchronous, active low) clears the decoder state, sets line and
// column to one and empties the output register.
// Depends on utf8v_pkg, utf8v_decode and utf8v_position.
module utf8_validate_line_column import utf8v_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_run_i,
  // Output channel.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   scalar_done_o,
  output logic [SCALAR_BITS-1:0] scalar_value_o,
  output logic                   bad_encoding_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [COLUMN_BITS-1:0] column_number_o,
  output logic                   run_done_o
);

  logic                   accept;
  utf8v_step_t            step;
  logic [LINE_BITS-1:0]   cur_line;
  logic [COLUMN_BITS-1:0] cur_col;

  logic                   out_valid_q;
  logic                   done_q;
  logic [SCALAR_BITS-1:0] value_q;
  logic                   bad_q;
  logic [LINE_BITS-1:0]   line_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic                   last_q;

  // A new byte may enter whenever the output register is empty or is being
  // emptied in this cycle, so a stalled consumer only stalls the producer.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The decoder owns the sequence state and the sticky error flag.
  utf8v_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .end_of_run_i (end_of_run_i),
    .step_o       (step)
  );

  // The position counters report where the current scalar starts and advance
  // after each completed scalar.
  utf8v_position u_position (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .step_i   (step),
    .line_o   (cur_line),
    .column_o (cur_col)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload. Line and column read zero when no scalar completes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q  <= step.done;
      value_q <= step.value;
      bad_q   <= step.error;
      line_q  <= step.done ? cur_line : '0;
      col_q   <= step.done ? cur_col : '0;
      last_q  <= step.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scalar_done_o   = done_q;
  assign scalar_value_o  = value_q;
  assign bad_encoding_o  = bad_q;
  assign line_number_o   = line_q;
  assign column_number_o = col_q;
  assign run_done_o      = last_q;

endmodule

@@ design/utf8v_decode.sv @@
// Sequence decoder: holds the open-sequence state and the sticky error flag,
// and works out the result of one byte. Depends on utf8v_pkg.
module utf8v_decode import utf8v_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_run_i,
  output utf8v_step_t step_o
);

  logic [1:0]             rem_q, rem_d;
  logic [2:0]             len_q, len_d;
  logic [SCALAR_BITS-1:0] part_q, part_d;
  logic                   err_q, err_d;
  logic [SCALAR_BITS-1:0] shifted;
  logic                   bad_scalar;
  logic                   done;
  logic [SCALAR_BITS-1:0] value;

  assign shifted = {part_q[SCALAR_BITS-7:0], data_byte_i[5:0]};

  // Overlong three- and four-byte forms, surrogates and out-of-range values.
  assign bad_scalar = ((len_q == SEQ_THREE) && (shifted < MIN_THREE_BYTE)) ||
                      ((len_q == SEQ_FOUR) && (shifted < MIN_FOUR_BYTE)) ||
                      ((shifted >= SURROGATE_LO) && (shifted <= SURROGATE_HI)) ||
                      (shifted > SCALAR_MAX);

  always_comb begin
    rem_d  = rem_q;
    len_d  = len_q;
    part_d = part_q;
    err_d  = err_q;
    done   = 1'b0;
    value  = '0;
    if (!err_q) begin
      if (rem_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          value = {{(SCALAR_BITS-8){1'b0}}, data_byte_i};
          done  = 1'b1;
        end else if ((data_byte_i >= LEAD2_MIN) && (data_byte_i <= LEAD2_MAX)) begin
          rem_d  = 2'd1;
          len_d  = SEQ_TWO;
          part_d = {{(SCALAR_BITS-5){1'b0}}, data_byte_i[4:0]};
        end else if ((data_byte_i >= LEAD3_MIN) && (data_byte_i <= LEAD3_MAX)) begin
          rem_d  = 2'd2;
          len_d  = SEQ_THREE;
          part_d = {{(SCALAR_BITS-4){1'b0}}, data_byte_i[3:0]};
        end else if ((data_byte_i >= LEAD4_MIN) && (data_byte_i <= LEAD4_MAX)) begin
          rem_d  = 2'd3;
          len_d  = SEQ_FOUR;
          part_d = {{(SCALAR_BITS-3){1'b0}}, data_byte_i[2:0]};
        end else begin
          err_d = 1'b1;
        end
      end else if (data_byte_i[7:6] != CONT_TAG) begin
        err_d = 1'b1;
      end else begin
        part_d = shifted;
        rem_d  = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          if (bad_scalar) begin
            err_d = 1'b1;
          end else begin
            value = shifted;
            done  = 1'b1;
          end
          len_d  = SEQ_NONE;
          part_d = '0;
        end
      end

      if (err_d) begin
        rem_d  = 2'd0;
        len_d  = SEQ_NONE;
        part_d = '0;
      end else if (!done && end_of_run_i && (rem_d != 2'd0)) begin
        // The run ends in the middle of a sequence.
        err_d = 1'b1;
      end
    end
  end

  assign step_o.done  = done;
  assign step_o.value = value;
  assign step_o.error = err_d;
  assign step_o.last  = end_of_run_i;

  // All state returns to its reset values after the last byte of a run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      len_q  <= SEQ_NONE;
      part_q <= '0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      if (end_of_run_i) begin
        rem_q  <= 2'd0;
        len_q  <= SEQ_NONE;
        part_q <= '0;
        err_q  <= 1'b0;
      end else begin
        rem_q  <= rem_d;
        len_q  <= len_d;
        part_q <= part_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

@@ design/utf8v_position.sv @@
// Line and column counters, saturating, both starting at one.
// Depends on utf8v_pkg.
module utf8v_position import utf8v_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  utf8v_step_t            step_i,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] column_o
);

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (step_i.last) begin
      line_d = LINE_ONE;
      col_d  = COL_ONE;
    end else if (step_i.done) begin
      if (step_i.value == NEWLINE) begin
        if (line_q != '1) begin
          line_d = line_q + LINE_ONE;
        end
        col_d = COL_ONE;
      end else if (col_q != '1) begin
        col_d = col_q + COL_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_ONE;
      col_q  <= COL_ONE;
    end else if (accept_i) begin
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  assign line_o   = line_q;
  assign column_o = col_q;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the strict UTF-8 validator with line and column tracking.
// Holds a scoreboard class that predicts every result, plus tasks that drive the byte stream.
// Depends on utf8v_pkg and the utf8_validate_line_column top level.
module tb;
  import utf8v_pkg::*;

  // A watchdog ends the run after this many cycles with no transfer on either side.
  localparam int STALL_LIMIT  = 4000;
  // Length of the forced receiver hold-off that fills the block.
  localparam int HOLD_CYCLES  = 300;
  // Cycles waited after the last expected result.
  localparam int DRAIN_CYCLES = 10;
  // Live bytes per random phase.
  localparam int PHASE_BYTES  = 125;

  // One result of the block, field by field.
  typedef struct packed {
    logic                   done;
    logic [SCALAR_BITS-1:0] value;
    logic                   bad;
    logic [LINE_BITS-1:0]   line_no;
    logic [COLUMN_BITS-1:0] col_no;
    logic                   run_end;
  } decoded_t;

  // Keeps its own copy of the decoder state, predicts the result of every accepted
  // byte and compares each transferred result with the oldest prediction.
  class scalar_scoreboard;
    logic [1:0]             cont_left;
    logic [2:0]             open_len;
    logic [SCALAR_BITS-1:0] gathered;
    logic [LINE_BITS-1:0]   cur_line;
    logic [COLUMN_BITS-1:0] cur_col;
    logic                   in_error;
    decoded_t               expected_results[$];
    int                     faults;
    int                     live_bytes;

    function new();
      faults = 0;
      live_bytes = 0;
      clear_state();
    endfunction

    function void clear_state();
      cont_left = '0;
      open_len  = SEQ_NONE;
      gathered  = '0;
      cur_line  = 1;
      cur_col   = 1;
      in_error  = 1'b0;
    endfunction

    function decoded_t predict_byte(logic [7:0] b, logic last);
      decoded_t r;
      logic [SCALAR_BITS-1:0] s;
      r = '0;
      r.run_end = last;
      if (!in_error) begin
        live_bytes++;
        if (cont_left == 0) begin
          if (b <= 8'h7F) begin
            r.done  = 1'b1;
            r.value = {13'b0, b};
          end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            cont_left = 1; open_len = SEQ_TWO;   gathered = {16'b0, b[4:0]};
          end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            cont_left = 2; open_len = SEQ_THREE; gathered = {17'b0, b[3:0]};
          end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            cont_left = 3; open_len = SEQ_FOUR;  gathered = {18'b0, b[2:0]};
          end else begin
            in_error = 1'b1;
          end
        end else if (b[7:6] != CONT_TAG) begin
          in_error = 1'b1;
        end else begin
          gathered  = {gathered[SCALAR_BITS-7:0], b[5:0]};
          cont_left = cont_left - 1'b1;
          if (cont_left == 0) begin
            s = gathered;
            if ((open_len == SEQ_THREE && s < MIN_THREE_BYTE) ||
                (open_len == SEQ_FOUR && s < MIN_FOUR_BYTE) ||
                (s >= SURROGATE_LO && s <= SURROGATE_HI) || s > SCALAR_MAX) begin
              in_error = 1'b1;
            end else begin
              r.done  = 1'b1;
              r.value = s;
            end
            open_len = SEQ_NONE;
            gathered = '0;
          end
        end

        if (in_error) begin
          cont_left = '0;
          open_len  = SEQ_NONE;
          gathered  = '0;
        end else if (r.done) begin
          r.line_no = cur_line;
          r.col_no  = cur_col;
          if (r.value == NEWLINE) begin
            if (cur_line != '1) cur_line++;
            cur_col = 1;
          end else if (cur_col != '1) begin
            cur_col++;
          end
        end else if (last && cont_left != 0) begin
          // The run ends inside an open sequence.
          in_error = 1'b1;
        end
      end
      r.bad = in_error;
      if (last) clear_state();
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      expected_results.insert(expected_results.size(), predict_byte(b, last));
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      if (expected_results.size() == 0) begin
        $error("result transferred with none expected: %p", got);
        faults++;
        return;
      end
      want = expected_results.pop_front();
      if (got.done !== want.done) begin
        $error("scalar_done: expected %0h, got %0h", want.done, got.done);
        faults++;
      end
      if (got.value !== want.value) begin
        $error("scalar_value: expected %0h, got %0h", want.value, got.value);
        faults++;
      end
      if (got.bad !== want.bad) begin
        $error("bad_encoding: expected %0h, got %0h", want.bad, got.bad);
        faults++;
      end
      if (got.line_no !== want.line_no) begin
        $error("line_number: expected %0d, got %0d", want.line_no, got.line_no);
        faults++;
      end
      if (got.col_no !== want.col_no) begin
        $error("column_number: expected %0d, got %0d", want.col_no, got.col_no);
        faults++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_done: expected %0h, got %0h", want.run_end, got.run_end);
        faults++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i = '0;
  logic                   end_of_run_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   scalar_done_o;
  logic [SCALAR_BITS-1:0] scalar_value_o;
  logic                   bad_encoding_o;
  logic [LINE_BITS-1:0]   line_number_o;
  logic [COLUMN_BITS-1:0] column_number_o;
  logic                   run_done_o;

  utf8_validate_line_column DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_run_i   (end_of_run_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scalar_done_o  (scalar_done_o),
    .scalar_value_o (scalar_value_o),
    .bad_encoding_o (bad_encoding_o),
    .line_number_o  (line_number_o),
    .column_number_o(column_number_o),
    .run_done_o     (run_done_o)
  );

  scalar_scoreboard board = new();

  // Percent of cycles in which the sender idles and the receiver stalls.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;

  // Bytes of the run being built, sent in order with the run end on the last one.
  logic [7:0] run_bytes[$];

  // Appends one byte to the run being built.
  function automatic void add_byte(logic [7:0] b);
    run_bytes.insert(run_bytes.size(), b);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: every value read right after the edge is the one the edge sampled, so a
  // transfer seen here is exactly the one the block made. The ready for the next edge
  // is chosen once per cycle.
  initial begin : receiver
    int hold_left;
    decoded_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.done    = scalar_done_o;
        got.value   = scalar_value_o;
        got.bad     = bad_encoding_o;
        got.line_no = line_number_o;
        got.col_no  = column_number_o;
        got.run_end = run_done_o;
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel makes a transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offers one byte, after a random number of idle cycles, and holds it until the
  // block takes it. Called right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    end_of_run_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(b, last);
  endtask

  // Sends the bytes gathered in run_bytes as one run and empties the list.
  task automatic send_run();
    foreach (run_bytes[i]) send_byte(run_bytes[i], i == run_bytes.size() - 1);
    run_bytes.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  // Appends the shortest encoding of a code point.
  function automatic void push_scalar(logic [SCALAR_BITS-1:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < MIN_THREE_BYTE) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({CONT_TAG, cp[5:0]});
    end else if (cp < MIN_FOUR_BYTE) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({CONT_TAG, cp[11:6]});
      add_byte({CONT_TAG, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({CONT_TAG, cp[17:12]});
      add_byte({CONT_TAG, cp[11:6]});
      add_byte({CONT_TAG, cp[5:0]});
    end
  endfunction

  // Appends a faulty piece to the run. Returns 1 when the piece is a sequence cut
  // off by the run end, after which nothing more may be appended.
  function automatic bit push_noise();
    logic [7:0] b;
    int conts;
    bit cut;
    cut = 1'b0;
    case ($urandom_range(7))
      0: add_byte(8'($urandom));
      1: begin
        // Lead bytes that can never start a sequence.
        if ($urandom_range(1)) add_byte(8'($urandom_range(8'hC1, 8'h80)));
        else add_byte(8'($urandom_range(8'hFF, 8'hF5)));
      end
      2: begin
        // A valid lead followed by a byte that is not a continuation.
        add_byte(8'($urandom_range(LEAD4_MAX, LEAD2_MIN)));
        b = 8'($urandom);
        while (b[7:6] == CONT_TAG) b = 8'($urandom);
        add_byte(b);
      end
      3: begin
        // Overlong three-byte form.
        add_byte(LEAD3_MIN);
        add_byte(8'($urandom_range(8'h9F, 8'h80)));
        add_byte(cont_byte());
      end
      4: begin
        // Overlong four-byte form.
        add_byte(LEAD4_MIN);
        add_byte(8'($urandom_range(8'h8F, 8'h80)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      5: begin
        // Surrogate.
        add_byte(8'hED);
        add_byte(8'($urandom_range(8'hBF, 8'hA0)));
        add_byte(cont_byte());
      end
      6: begin
        // Above the largest scalar.
        add_byte(LEAD4_MAX);
        add_byte(8'($urandom_range(8'hBF, 8'h90)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      default: begin
        // A sequence that the run end cuts off.
        b = 8'($urandom_range(LEAD4_MAX, LEAD2_MIN));
        add_byte(b);
        conts = (b >= LEAD4_MIN) ? 2 : (b >= LEAD3_MIN) ? 1 : 0;
        conts = $urandom_range(conts);
        repeat (conts) add_byte(cont_byte());
        cut = 1'b1;
      end
    endcase
    return cut;
  endfunction

  // Builds one run of mostly well-formed scalars with random content.
  task automatic build_run();
    int count;
    int pick;
    logic [SCALAR_BITS-1:0] cp;
    count = $urandom_range(12, 1);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_scalar(21'($urandom_range(8'h7F)));
      end else if (pick < 38) begin
        push_scalar(NEWLINE);
      end else if (pick < 55) begin
        push_scalar(21'($urandom_range(12'h7FF, 8'h80)));
      end else if (pick < 75) begin
        cp = 21'($urandom_range(16'hFFFF, 12'h800));
        if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp + 21'h800;
        push_scalar(cp);
      end else if (pick < 90) begin
        push_scalar(21'($urandom_range(SCALAR_MAX, MIN_FOUR_BYTE)));
      end else if (push_noise()) begin
        break;
      end
    end
  endtask

  // Sends random runs until PHASE_BYTES more bytes have reached the decoder
  // outside an error state.
  task automatic random_phase(input int sidle, input int rstall, input bit squeeze);
    int goal;
    bit asked;
    goal = board.live_bytes + PHASE_BYTES;
    asked = 1'b0;
    sender_idle_pct = sidle;
    recv_stall_pct  = rstall;
    while (board.live_bytes < goal) begin
      build_run();
      send_run();
      if (squeeze && !asked && board.live_bytes > goal - PHASE_BYTES / 2) begin
        // The sender keeps offering bytes while the receiver holds off.
        hold_request = 1'b1;
        asked = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed run: the field extremes and the smallest and largest scalar of
    // every sequence length, with a newline in between.
    run_bytes = '{8'h00, 8'h0A, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                  8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                  8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_run();
    // Bad lead byte; the byte after it is ignored.
    run_bytes = '{8'hC1, 8'h41};
    send_run();
    // Sequence cut off by the run end.
    run_bytes = '{8'hE2, 8'h82};
    send_run();

    // Random runs under each idling pattern, with one long receiver hold-off.
    random_phase(0, 0, 1'b1);
    random_phase(53, 0, 1'b0);
    random_phase(0, 53, 1'b0);
    random_phase(19, 19, 1'b0);
    random_phase(0, 0, 1'b0);
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
